// ===== rtl/cba_pkg.sv =====
// Package for the contiguous block allocator: map size, field widths,
// request and status codes, and the ring control bundle.
// No dependencies.
package cba_pkg;

  // Owner map size
  localparam int NUM_BLOCKS = 16;

  // Derived widths
  localparam int BLK_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int ID_W    = 8;
  localparam int LEN_W   = 5;
  localparam int START_W = 4;
  localparam int FREED_W = 5;
  localparam int STAT_W  = 2;
  localparam int CMP_W   = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_ROOM   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FREED     = 2'd2;

  // Saturation value of the freed count
  localparam logic [FREED_W-1:0] FREED_MAX = '1;

  typedef logic [ID_W-1:0] owner_t;

  // Ring control from the sequencer to the cells
  typedef struct packed {
    logic   shift;
    owner_t fill;
  } ring_ctl_t;

endpackage

// ===== rtl/cba_cell.sv =====
// One cell of the owner ring: holds the owner id of one block and takes
// its neighbor's value on every shift. Depends on cba_pkg.
module cba_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  cba_pkg::owner_t owner_i,
  output cba_pkg::owner_t owner_o
);

  cba_pkg::owner_t owner_q;

  // Advance on shift, clear to free on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
    end else if (shift_i) begin
      owner_q <= owner_i;
    end
  end

  assign owner_o = owner_q;

endmodule

// ===== rtl/cba_ctrl.sv =====
// Sequencer of the allocator: rotates the owner ring past its head, runs
// the first-fit search, the write pass and the free pass. Depends on cba_pkg.
module cba_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             req_type_i,
  input  logic [cba_pkg::ID_W-1:0]         file_id_i,
  input  logic [cba_pkg::LEN_W-1:0]        run_length_i,
  input  cba_pkg::owner_t                  head_i,
  output cba_pkg::ring_ctl_t               ring_o,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [cba_pkg::STAT_W-1:0]       status_o,
  output logic [cba_pkg::START_W-1:0]      start_block_o,
  output logic [cba_pkg::FREED_W-1:0]      freed_count_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [cba_pkg::BLK_W-1:0] LAST_POS =
    cba_pkg::BLK_W'(cba_pkg::NUM_BLOCKS - 1);

  logic [1:0]                      state_q, state_d;
  logic                            type_q;
  cba_pkg::owner_t                 id_q;
  logic [cba_pkg::LEN_W-1:0]       len_q;
  logic [cba_pkg::BLK_W-1:0]       pos_q, pos_d;
  logic [cba_pkg::CNT_W-1:0]       run_q, run_d;
  logic                            found_q, found_d;
  logic [cba_pkg::BLK_W-1:0]       start_q, start_d;
  logic [cba_pkg::FREED_W-1:0]     freed_q, freed_d;
  logic [cba_pkg::STAT_W-1:0]      status_q, status_d;

  logic                            accept;
  logic                            last;
  logic [cba_pkg::CMP_W-1:0]       run_inc;
  logic [cba_pkg::CMP_W-1:0]       len_ext;
  logic [cba_pkg::CMP_W-1:0]       pos_ext;
  logic [cba_pkg::CMP_W-1:0]       start_ext;
  logic [cba_pkg::CMP_W-1:0]       start_calc;
  logic                            in_run;

  assign accept     = start_i && (state_q == S_IDLE);
  assign last       = (pos_q == LAST_POS);
  assign len_ext    = cba_pkg::CMP_W'(len_q);
  assign pos_ext    = cba_pkg::CMP_W'(pos_q);
  assign start_ext  = cba_pkg::CMP_W'(start_q);
  assign run_inc    = cba_pkg::CMP_W'(run_q) + cba_pkg::CMP_W'(1);
  assign start_calc = pos_ext + cba_pkg::CMP_W'(1) - len_ext;
  assign in_run     = (pos_ext >= start_ext) && ((pos_ext - start_ext) < len_ext);

  // Sequence the passes over the ring
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    run_d       = run_q;
    found_d     = found_q;
    start_d     = start_q;
    freed_d     = freed_q;
    status_d    = status_q;
    ring_o.shift = 1'b0;
    ring_o.fill  = head_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          pos_d   = '0;
          run_d   = '0;
          found_d = 1'b0;
          start_d = '0;
          freed_d = '0;
        end
      end
      S_SCAN: begin
        ring_o.shift = 1'b1;
        pos_d        = pos_q + cba_pkg::BLK_W'(1);
        if (type_q == cba_pkg::REQ_FREE) begin
          // Release blocks of this owner and count them
          if ((id_q != '0) && (head_i == id_q)) begin
            ring_o.fill = '0;
            if (freed_q != cba_pkg::FREED_MAX) begin
              freed_d = freed_q + cba_pkg::FREED_W'(1);
            end
          end
          if (last) begin
            state_d  = S_DONE;
            status_d = cba_pkg::ST_FREED;
          end
        end else begin
          // Track the current free run until the first fit
          if (!found_q) begin
            if (head_i == '0) begin
              run_d = cba_pkg::CNT_W'(run_inc);
              if ((run_inc == len_ext) && (id_q != '0)) begin
                found_d = 1'b1;
                start_d = cba_pkg::BLK_W'(start_calc);
              end
            end else begin
              run_d = '0;
            end
          end
          if (last) begin
            pos_d = '0;
            if (found_d) begin
              state_d = S_WRITE;
            end else begin
              state_d  = S_DONE;
              status_d = cba_pkg::ST_NO_ROOM;
              start_d  = '0;
            end
          end
        end
      end
      S_WRITE: begin
        // Mark the found run with the owner id
        ring_o.shift = 1'b1;
        pos_d        = pos_q + cba_pkg::BLK_W'(1);
        if (in_run) begin
          ring_o.fill = id_q;
        end
        if (last) begin
          state_d  = S_DONE;
          status_d = cba_pkg::ST_ALLOCATED;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Transaction payload and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q <= req_type_i;
      id_q   <= file_id_i;
      len_q  <= run_length_i;
    end
    pos_q    <= pos_d;
    run_q    <= run_d;
    found_q  <= found_d;
    start_q  <= start_d;
    freed_q  <= freed_d;
    status_q <= status_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = (state_q == S_DONE);
  assign status_o      = status_q;
  assign start_block_o = cba_pkg::START_W'(start_q);
  assign freed_count_o = freed_q;

endmodule

// ===== rtl/contiguous_block_allocator_unit.sv =====
// Top level of the first-fit contiguous block allocator: a ring of owner
// cells and the sequencer that rotates it. Depends on cba_pkg, cba_cell, cba_ctrl.
//
// A request is taken when start_i is high and busy_o low. The owner map
// sits in a ring of NUM_BLOCKS cells that rotates one block a cycle past
// the sequencer while a pass runs. A free, or an allocate that finds no
// room, takes one rotation; an allocate that fits takes a search rotation
// and a write rotation. done_o pulses when the last rotation ends. busy_o
// stays high through the done_o cycle and drops in the cycle after it, so
// the next request is taken only once busy_o is low. The result stays on
// the ports until the next request is taken and cannot be held off past
// that; capture it when done_o is high.
module contiguous_block_allocator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             req_type_i,
  input  logic [cba_pkg::ID_W-1:0]         file_id_i,
  input  logic [cba_pkg::LEN_W-1:0]        run_length_i,
  output logic                             done_o,
  output logic [cba_pkg::STAT_W-1:0]       status_o,
  output logic [cba_pkg::START_W-1:0]      start_block_o,
  output logic [cba_pkg::FREED_W-1:0]      freed_count_o
);

  cba_pkg::ring_ctl_t ring;
  cba_pkg::owner_t    owner [cba_pkg::NUM_BLOCKS];

  // Rotate the ring toward cell zero; the sequencer refills the far end
  for (genvar i = 0; i < cba_pkg::NUM_BLOCKS; i++) begin : g_cell
    cba_pkg::owner_t nbr;
    if (i == cba_pkg::NUM_BLOCKS - 1) begin : g_tail
      assign nbr = ring.fill;
    end else begin : g_body
      assign nbr = owner[i+1];
    end
    cba_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ring.shift),
      .owner_i (nbr),
      .owner_o (owner[i])
    );
  end

  cba_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .req_type_i    (req_type_i),
    .file_id_i     (file_id_i),
    .run_length_i  (run_length_i),
    .head_i        (owner[0]),
    .ring_o        (ring),
    .busy_o        (busy_o),
    .done_o        (done_o),
    .status_o      (status_o),
    .start_block_o (start_block_o),
    .freed_count_o (freed_count_o)
  );

endmodule

// ===== rtl/cba_checker.sv =====
// Port checker for the contiguous block allocator, bound to the top level.
// Depends on cba_pkg and contiguous_block_allocator_unit.
module cba_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start_i,
  input logic                             busy_o,
  input logic                             done_o,
  input logic [cba_pkg::STAT_W-1:0]       status_o,
  input logic [cba_pkg::START_W-1:0]      start_block_o,
  input logic [cba_pkg::FREED_W-1:0]      freed_count_o
);

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("block not busy after accepted transaction");

  // A result is shown only while busy, and the block is free right after
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy_o ##1 !busy_o))
    else $error("done strobe outside a busy window");

  // A single strobe per transaction
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  // Start block is zero unless a run was allocated
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != cba_pkg::ST_ALLOCATED)) |-> (start_block_o == '0))
    else $error("start block nonzero without an allocation");

  // Freed count is zero unless the transaction was a free
  a_freed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != cba_pkg::ST_FREED)) |-> (freed_count_o == '0))
    else $error("freed count nonzero on an allocate");

endmodule

bind contiguous_block_allocator_unit cba_checker u_cba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .start_block_o (start_block_o),
  .freed_count_o (freed_count_o)
);
